FILE: src/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared widths, constants and controller/datapath interface types for the
// cpu load estimator.
// ----------------------------------------------------------------------------
package cle_pkg;

  // field and state widths
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int WIN_W   = 10;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = COUNT_W + TIME_W;

  // window length reset value in ms
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(25);

  // scaling constants
  localparam int US_PER_MS = 1000;
  localparam int PCT_SCALE = 100;

  // total window length in us fits 20 bits (1023 * 1000)
  localparam int TOTAL_W = 20;
  // work * 100 fits 27 bits
  localparam int NUM_W   = 27;

  // quotient bits of the load divide, one per step
  localparam int QUOT_W    = PCT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // latch transaction and update per-pass state
    logic mul;      // form pass_count * avg_pass_time
    logic scale;    // cap idle, form work * 100, load divider
    logic div_step; // one restoring divide step
    logic finish;   // commit load, peak, average, close window
    logic publish;  // load output register
  } cle_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic closed;   // the current pass closes a window
  } cle_status_t;

endpackage

FILE: src/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Pass counting, pass-time averaging, window check, idle product, restoring
// load divider and the output register.
// ----------------------------------------------------------------------------
module cle_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cle_pkg::WIN_W-1:0]   cfg_wdata,
  input  logic [cle_pkg::TIME_W-1:0]  now_us,
  input  logic [cle_pkg::TIME_W-1:0]  now_ms,
  input  logic                        preempted,
  input  cle_pkg::cle_cmd_t           cmd,
  output cle_pkg::cle_status_t        status,
  output logic [cle_pkg::PCT_W-1:0]   load_pct,
  output logic [cle_pkg::PCT_W-1:0]   peak_pct,
  output logic [cle_pkg::PCT_W-1:0]   average_pct,
  output logic                        window_closed
);

  // configuration
  logic [cle_pkg::WIN_W-1:0]   window_ms;

  // architectural state
  logic [cle_pkg::COUNT_W-1:0] pass_count;
  logic [cle_pkg::TIME_W-1:0]  avg_pass_time;
  logic [cle_pkg::TIME_W-1:0]  last_pass_start;
  logic [cle_pkg::TIME_W-1:0]  window_start_ms;
  logic [cle_pkg::PCT_W-1:0]   last_load;
  logic [cle_pkg::PCT_W-1:0]   peak_load;
  logic [cle_pkg::PCT_W-1:0]   average_load;

  // per-transaction working registers
  logic                        closed;
  logic [cle_pkg::TIME_W-1:0]  now_ms_q;
  logic [cle_pkg::TOTAL_W-1:0] total;
  logic [cle_pkg::PROD_W-1:0]  product;
  logic [cle_pkg::NUM_W-1:0]   rem;
  logic [cle_pkg::NUM_W-1:0]   divisor;
  logic [cle_pkg::QUOT_W-1:0]  quot;

  // combinational terms
  logic [cle_pkg::COUNT_W-1:0] pass_count_next;
  logic [cle_pkg::TIME_W-1:0]  pass_sum;
  logic [cle_pkg::TIME_W-1:0]  avg_pass_time_next;
  logic [cle_pkg::TIME_W-1:0]  ms_elapsed;
  logic                        closed_next;
  logic                        idle_capped;
  logic [cle_pkg::TOTAL_W-1:0] idle;
  logic [cle_pkg::TOTAL_W-1:0] work;
  logic [cle_pkg::PCT_W-1:0]   load;
  logic [cle_pkg::PCT_W:0]     avg_sum;

  // per-pass updates
  always_comb begin
    pass_count_next = (pass_count == '1) ? pass_count : pass_count + 1'b1;
    pass_sum = avg_pass_time + (now_us - last_pass_start);
    avg_pass_time_next = preempted ? avg_pass_time : (pass_sum >> 1);
    ms_elapsed = now_ms - window_start_ms;
    closed_next = ms_elapsed >= cle_pkg::TIME_W'(window_ms);
  end

  // idle time capped at the window length, then work scaled to percent
  always_comb begin
    idle_capped = (|product[cle_pkg::PROD_W-1:cle_pkg::TOTAL_W]) ||
                  (product[cle_pkg::TOTAL_W-1:0] > total);
    idle = idle_capped ? total : product[cle_pkg::TOTAL_W-1:0];
    work = total - idle;
  end

  // final load and running average
  always_comb begin
    load = (total == '0) ? '0 : quot;
    avg_sum = {1'b0, average_load} + {1'b0, load};
  end

  assign status.closed = closed;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= cle_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_ms <= cfg_wdata;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count      <= '0;
      avg_pass_time   <= '0;
      last_pass_start <= '0;
      window_start_ms <= '0;
      last_load       <= '0;
      peak_load       <= '0;
      average_load    <= '0;
      closed          <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pass_count      <= pass_count_next;
        avg_pass_time   <= avg_pass_time_next;
        last_pass_start <= now_us;
        closed          <= closed_next;
      end
      if (cmd.finish) begin
        last_load       <= load;
        peak_load       <= (load > peak_load) ? load : peak_load;
        average_load    <= avg_sum[cle_pkg::PCT_W:1];
        pass_count      <= '0;
        window_start_ms <= now_ms_q;
      end
    end
  end

  // working registers: multiply, scale and restoring divide
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_ms_q <= now_ms;
      total    <= cle_pkg::TOTAL_W'(window_ms) * cle_pkg::TOTAL_W'(cle_pkg::US_PER_MS);
    end
    if (cmd.mul) begin
      product <= cle_pkg::PROD_W'(pass_count) * cle_pkg::PROD_W'(avg_pass_time);
    end
    if (cmd.scale) begin
      rem     <= cle_pkg::NUM_W'(work) * cle_pkg::NUM_W'(cle_pkg::PCT_SCALE);
      divisor <= cle_pkg::NUM_W'(total) << (cle_pkg::QUOT_W - 1);
      quot    <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= divisor) begin
        rem  <= rem - divisor;
        quot <= {quot[cle_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        quot <= {quot[cle_pkg::QUOT_W-2:0], 1'b0};
      end
      divisor <= divisor >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      load_pct      <= last_load;
      peak_pct      <= peak_load;
      average_pct   <= average_load;
      window_closed <= closed;
    end
  end

endmodule

FILE: src/cle_controller.sv
// ----------------------------------------------------------------------------
// cle_controller
// Sequencer for one transaction: accept, multiply, scale, divide, commit and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module cle_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cle_pkg::cle_status_t status,
  output cle_pkg::cle_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_FIN,
    ST_PUB
  } state_t;

  state_t                        state;
  logic [cle_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          div_last;

  assign in_ready = (state == ST_IDLE);
  assign div_last = (div_cnt == cle_pkg::DIV_CNT_W'(cle_pkg::QUOT_W - 1));

  // datapath commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    cmd.mul      = (state == ST_MUL);
    cmd.scale    = (state == ST_SCALE);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_FIN);
    cmd.publish  = (state == ST_PUB) && (!out_valid || out_ready);
  end

  // state, divide step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= status.closed ? ST_SCALE : ST_PUB;
        end
        ST_SCALE: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_PUB;
        end
        ST_PUB: begin
          if (cmd.publish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a transaction leaves idle right away
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready)
    else $error("input taken again while busy");

  // the divide runs exactly its quotient width in steps
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt <= cle_pkg::DIV_CNT_W'(cle_pkg::QUOT_W - 1)))
    else $error("divide step counter overran");

  // commit only follows the last divide step
  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> ($past(state) == ST_DIV))
    else $error("commit without divide");

  // a published result is presented next cycle
  a_pub_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not presented");

endmodule

FILE: src/cpu_load_estimator_core.sv
// Sequence: accept and multiply, then publish when no window closes; when
//   one closes, scale, 7-step divide and commit come before the publish.
// Flow: the 7-step restoring load divider makes a closing transaction longer.
//   A new transaction is accepted only after publish. A finished result may
//   wait in the output register while the next transaction is accepted.
// Reset: synchronous active-high rst clears all but the working and output registers; window_ms returns to 25.
// ----------------------------------------------------------------------------
// cpu_load_estimator_core
// CPU load estimate from idle-loop passes: controller plus datapath.
// ----------------------------------------------------------------------------
module cpu_load_estimator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cle_pkg::WIN_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cle_pkg::TIME_W-1:0] now_us,
  input  logic [cle_pkg::TIME_W-1:0] now_ms,
  input  logic                       preempted,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cle_pkg::PCT_W-1:0]  load_pct,
  output logic [cle_pkg::PCT_W-1:0]  peak_pct,
  output logic [cle_pkg::PCT_W-1:0]  average_pct,
  output logic                       window_closed
);

  cle_pkg::cle_cmd_t    cmd;
  cle_pkg::cle_status_t status;

  // sequencer
  cle_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and state
  cle_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .now_us        (now_us),
    .now_ms        (now_ms),
    .preempted     (preempted),
    .cmd           (cmd),
    .status        (status),
    .load_pct      (load_pct),
    .peak_pct      (peak_pct),
    .average_pct   (average_pct),
    .window_closed (window_closed)
  );

endmodule
